@@ rtl/core/dense_polynomial_mul_add_defines.svh @@
// assertion macros for the dense polynomial multiply and add block
// no dependencies; included by the top level
`ifndef DENSE_POLYNOMIAL_MUL_ADD_DEFINES_SVH
`define DENSE_POLYNOMIAL_MUL_ADD_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication check
`define DPMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpma check failed");
// next-cycle implication check
`define DPMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpma check failed");
`else
`define DPMA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DPMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/dpma_pkg.sv @@
// shared constants, request codes and types of the polynomial block
// no dependencies
`timescale 1ns / 1ps

package dpma_pkg;

   localparam int ACTION_W    = 3;
   localparam int COEF_IN_W   = 16;
   localparam int EXP_IN_W    = 10;
   localparam int TERM_COEF_W = 48;
   localparam int TERM_EXP_W  = 11;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_COMPUTE     = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FETCH_PROD  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FETCH_SUM   = 3'd5;

   // issue controls from the sequencer to the multiply-accumulate pipe
   typedef struct packed {
      logic valid;
      logic wr_ok;
      logic load_a;
   } dpma_mac_ctl_type;

endpackage

@@ rtl/core/dpma_if.sv @@
// request and response channel interfaces of the polynomial block
// depends on dpma_pkg
`timescale 1ns / 1ps

interface dpma_req_if;
   import dpma_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic signed [COEF_IN_W-1:0] coefficient;
   logic [EXP_IN_W-1:0]         exponent;

   modport source (output valid, output action, output coefficient, output exponent,
                   input ready);
   modport sink   (input valid, input action, input coefficient, input exponent,
                   output ready);
endinterface

interface dpma_rsp_if;
   import dpma_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [TERM_COEF_W-1:0] term_coefficient;
   logic [TERM_EXP_W-1:0]         term_exponent;
   logic                          final_term;

   modport source (output valid, output term_coefficient, output term_exponent,
                   output final_term, input ready);
   modport sink   (input valid, input term_coefficient, input term_exponent,
                   input final_term, output ready);
endinterface

@@ rtl/core/dpma_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dpma_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/dpma_mac.sv @@
// multiply-accumulate pipe: multiply stage then add and write back
// depends on dpma_pkg
`timescale 1ns / 1ps

module dpma_mac
   import dpma_pkg::*;
#(
   parameter int PRODUCT_SLOTS = 2047,
   parameter int COEF_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dpma_mac_ctl_type                 mac_ctl,
   input  logic [$clog2(PRODUCT_SLOTS)-1:0] mac_addr,
   input  logic signed [COEF_BITS-1:0]      a_data,
   input  logic signed [COEF_BITS-1:0]      b_data,
   input  logic [TERM_COEF_W-1:0]           old_data,
   output logic                             wr_en,
   output logic [$clog2(PRODUCT_SLOTS)-1:0] wr_addr,
   output logic [TERM_COEF_W-1:0]           wr_data
);

   localparam int PW    = $clog2(PRODUCT_SLOTS);
   localparam int MUL_W = 2 * COEF_BITS;
   localparam int EXT_W = (MUL_W > TERM_COEF_W) ? MUL_W : TERM_COEF_W;

   logic signed [COEF_BITS-1:0] a_ff, a_in;
   logic                        v1_ff, v1_in, wr1_ff, wr1_in;
   logic [PW-1:0]               addr1_ff, addr1_in;
   logic                        v2_ff, v2_in, wr2_ff, wr2_in;
   logic [PW-1:0]               addr2_ff, addr2_in;
   logic signed [MUL_W-1:0]     mul_ff, mul_in;
   logic [TERM_COEF_W-1:0]      old_ff, old_in;
   logic signed [EXT_W-1:0]     mul_ext;

   // row coefficient, issue stage and multiply stage
   always_comb begin
      a_in     = mac_ctl.load_a ? a_data : a_ff;
      v1_in    = mac_ctl.valid;
      wr1_in   = mac_ctl.wr_ok;
      addr1_in = mac_addr;
      v2_in    = v1_ff;
      wr2_in   = wr1_ff;
      addr2_in = addr1_ff;
      mul_in   = a_ff * b_data;
      old_in   = old_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      wr1_ff   <= wr1_in;
      addr1_ff <= addr1_in;
      wr2_ff   <= wr2_in;
      addr2_ff <= addr2_in;
      mul_ff   <= mul_in;
      old_ff   <= old_in;
   end

   // accumulate, wrapping to the term width
   assign mul_ext = EXT_W'(mul_ff);
   assign wr_en   = v2_ff && wr2_ff;
   assign wr_addr = addr2_ff;
   assign wr_data = old_ff + mul_ext[TERM_COEF_W-1:0];

endmodule

@@ rtl/core/dpma_ctrl.sv @@
// sequencer: loads, clearing sweeps, product row walk and fetch scans
// depends on dpma_pkg and the channel interfaces
`timescale 1ns / 1ps

module dpma_ctrl
   import dpma_pkg::*;
#(
   parameter int TERM_SLOTS    = 1024,
   parameter int PRODUCT_SLOTS = 2047,
   parameter int COEF_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   dpma_req_if.sink                         req_bus,
   dpma_rsp_if.source                       rsp_bus,
   output logic                             first_wr_en,
   output logic                             second_wr_en,
   output logic [$clog2(TERM_SLOTS)-1:0]    term_wr_addr,
   output logic [COEF_BITS-1:0]             term_wr_data,
   output logic [$clog2(TERM_SLOTS)-1:0]    first_rd_addr,
   output logic [$clog2(TERM_SLOTS)-1:0]    second_rd_addr,
   input  logic [COEF_BITS-1:0]             first_rd_data,
   input  logic [COEF_BITS-1:0]             second_rd_data,
   output logic                             prod_sweep_en,
   output logic [$clog2(PRODUCT_SLOTS)-1:0] prod_sweep_addr,
   output logic [$clog2(PRODUCT_SLOTS)-1:0] prod_rd_addr,
   input  logic [TERM_COEF_W-1:0]           prod_rd_data,
   output dpma_mac_ctl_type                 mac_ctl,
   output logic [$clog2(PRODUCT_SLOTS)-1:0] mac_addr
);

   localparam int TW        = $clog2(TERM_SLOTS);
   localparam int PW        = $clog2(PRODUCT_SLOTS);
   localparam int MAX_SLOTS = (TERM_SLOTS > PRODUCT_SLOTS) ? TERM_SLOTS : PRODUCT_SLOTS;
   localparam int SW        = $clog2(MAX_SLOTS);
   localparam int RW        = $clog2(TERM_SLOTS + 1);

   // sequencer states
   localparam logic [3:0] S_INIT      = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_CLEAR     = 4'd2;
   localparam logic [3:0] S_ZERO      = 4'd3;
   localparam logic [3:0] S_ROW_START = 4'd4;
   localparam logic [3:0] S_ROW_LOAD  = 4'd5;
   localparam logic [3:0] S_MAC       = 4'd6;
   localparam logic [3:0] S_SCAN      = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [SW-1:0]                 sweep_ff, sweep_in;
   logic [RW-1:0]                 row_ff, row_in;
   logic [TW-1:0]                 col_ff, col_in;
   logic [SW-1:0]                 issue_addr_ff, issue_addr_in;
   logic                          issue_more_ff, issue_more_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [SW-1:0]                 rd_addr_ff, rd_addr_in;
   logic                          phase_ff, phase_in;
   logic                          use_prod_ff, use_prod_in;
   logic [SW-1:0]                 hit_addr_ff, hit_addr_in;
   logic [TERM_COEF_W-1:0]        hit_coef_ff, hit_coef_in;
   logic [TERM_COEF_W-1:0]        res_coef_ff, res_coef_in;
   logic [TERM_EXP_W-1:0]         res_exp_ff, res_exp_in;
   logic                          res_last_ff, res_last_in;
   logic                          out_valid_ff, out_valid_in;
   logic [TERM_COEF_W-1:0]        out_coef_ff, out_coef_in;
   logic [TERM_EXP_W-1:0]         out_exp_ff, out_exp_in;
   logic                          out_last_ff, out_last_in;
   logic [PW-1:0]                 prod_cursor_ff, prod_cursor_in;
   logic [TW-1:0]                 sum_cursor_ff, sum_cursor_in;
   logic                          prod_done_ff, prod_done_in;
   logic                          sum_done_ff, sum_done_in;

   logic                          req_fire;
   logic                          load_ok;
   logic [TW:0]                   mac_s;
   logic signed [COEF_BITS:0]     sum_w;
   logic [TERM_COEF_W-1:0]        sum_ext;
   logic [TERM_COEF_W-1:0]        scan_value;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign load_ok       = 32'(req_bus.exponent) < TERM_SLOTS;
   assign mac_s         = (TW+1)'(row_ff) + (TW+1)'(col_ff);

   // value under the scan: stored product or sum formed on the fly
   assign sum_w      = {first_rd_data[COEF_BITS-1], first_rd_data}
                     + {second_rd_data[COEF_BITS-1], second_rd_data};
   assign sum_ext    = TERM_COEF_W'(sum_w);
   assign scan_value = use_prod_ff ? prod_rd_data : sum_ext;

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      issue_addr_in  = issue_addr_ff;
      issue_more_in  = issue_more_ff;
      rd_valid_in    = rd_valid_ff;
      rd_addr_in     = rd_addr_ff;
      phase_in       = phase_ff;
      use_prod_in    = use_prod_ff;
      hit_addr_in    = hit_addr_ff;
      hit_coef_in    = hit_coef_ff;
      res_coef_in    = res_coef_ff;
      res_exp_in     = res_exp_ff;
      res_last_in    = res_last_ff;
      out_valid_in   = out_valid_ff;
      out_coef_in    = out_coef_ff;
      out_exp_in     = out_exp_ff;
      out_last_in    = out_last_ff;
      prod_cursor_in = prod_cursor_ff;
      sum_cursor_in  = sum_cursor_ff;
      prod_done_in   = prod_done_ff;
      sum_done_in    = sum_done_ff;

      first_wr_en     = 1'b0;
      second_wr_en    = 1'b0;
      term_wr_addr    = TW'(req_bus.exponent);
      term_wr_data    = COEF_BITS'($unsigned(req_bus.coefficient));
      first_rd_addr   = TW'(issue_addr_ff);
      second_rd_addr  = TW'(issue_addr_ff);
      prod_sweep_en   = 1'b0;
      prod_sweep_addr = PW'(sweep_ff);
      prod_rd_addr    = PW'(issue_addr_ff);
      mac_ctl         = '0;
      mac_addr        = PW'(mac_s);

      // response register drains independently of the sequencer
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         // clearing pass over every store after reset
         S_INIT: begin
            first_wr_en   = 32'(sweep_ff) < TERM_SLOTS;
            second_wr_en  = 32'(sweep_ff) < TERM_SLOTS;
            term_wr_addr  = TW'(sweep_ff);
            term_wr_data  = '0;
            prod_sweep_en = 32'(sweep_ff) < PRODUCT_SLOTS;
            if (sweep_ff == SW'(MAX_SLOTS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = SW'(sweep_ff + 1'b1);
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  ACT_LOAD_FIRST, ACT_LOAD_SECOND: begin
                     if (load_ok) begin
                        first_wr_en   = (req_bus.action == ACT_LOAD_FIRST);
                        second_wr_en  = (req_bus.action == ACT_LOAD_SECOND);
                        sum_cursor_in = TW'(TERM_SLOTS - 1);
                        sum_done_in   = 1'b0;
                     end
                  end
                  ACT_CLEAR: begin
                     sum_cursor_in  = TW'(TERM_SLOTS - 1);
                     sum_done_in    = 1'b0;
                     prod_cursor_in = PW'(PRODUCT_SLOTS - 1);
                     prod_done_in   = 1'b0;
                     sweep_in       = '0;
                     state_in       = S_CLEAR;
                  end
                  ACT_COMPUTE: begin
                     prod_cursor_in = PW'(PRODUCT_SLOTS - 1);
                     prod_done_in   = 1'b0;
                     sweep_in       = '0;
                     state_in       = S_ZERO;
                  end
                  ACT_FETCH_PROD: begin
                     if (!prod_done_ff) begin
                        issue_addr_in = SW'(prod_cursor_ff);
                        issue_more_in = 1'b1;
                        rd_valid_in   = 1'b0;
                        phase_in      = 1'b0;
                        use_prod_in   = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  ACT_FETCH_SUM: begin
                     if (!sum_done_ff) begin
                        issue_addr_in = SW'(sum_cursor_ff);
                        issue_more_in = 1'b1;
                        rd_valid_in   = 1'b0;
                        phase_in      = 1'b0;
                        use_prod_in   = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // zero both term stores
         S_CLEAR: begin
            first_wr_en  = 1'b1;
            second_wr_en = 1'b1;
            term_wr_addr = TW'(sweep_ff);
            term_wr_data = '0;
            if (sweep_ff == SW'(TERM_SLOTS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = SW'(sweep_ff + 1'b1);
            end
         end

         // zero the product store ahead of accumulation
         S_ZERO: begin
            prod_sweep_en = 1'b1;
            if (sweep_ff == SW'(PRODUCT_SLOTS - 1)) begin
               sweep_in = '0;
               row_in   = '0;
               state_in = S_ROW_START;
            end else begin
               sweep_in = SW'(sweep_ff + 1'b1);
            end
         end

         // fetch the row coefficient; the row start and row load states also drain the pipe
         S_ROW_START: begin
            first_rd_addr = TW'(row_ff);
            if (row_ff == RW'(TERM_SLOTS)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_ROW_LOAD;
            end
         end

         // rows with a zero coefficient add nothing and are skipped
         S_ROW_LOAD: begin
            mac_ctl.load_a = 1'b1;
            if (first_rd_data == '0) begin
               row_in   = RW'(row_ff + 1'b1);
               state_in = S_ROW_START;
            end else begin
               col_in   = '0;
               state_in = S_MAC;
            end
         end

         // one pair issued per cycle; slots within a row never repeat
         S_MAC: begin
            second_rd_addr = col_ff;
            prod_rd_addr   = PW'(mac_s);
            mac_ctl.valid  = 1'b1;
            mac_ctl.wr_ok  = 32'(mac_s) < PRODUCT_SLOTS;
            if (col_ff == TW'(TERM_SLOTS - 1)) begin
               row_in   = RW'(row_ff + 1'b1);
               state_in = S_ROW_START;
            end else begin
               col_in = TW'(col_ff + 1'b1);
            end
         end

         // downward scan: first finds the term, second looks for one below
         S_SCAN: begin
            if (rd_valid_ff && (scan_value != '0)) begin
               if (!phase_ff) begin
                  hit_addr_in = rd_addr_ff;
                  hit_coef_in = scan_value;
                  if (rd_addr_ff == '0) begin
                     res_coef_in = scan_value;
                     res_exp_in  = TERM_EXP_W'(rd_addr_ff);
                     res_last_in = 1'b1;
                     if (use_prod_ff) begin
                        prod_done_in = 1'b1;
                     end else begin
                        sum_done_in = 1'b1;
                     end
                     state_in = S_EMIT;
                  end else begin
                     phase_in      = 1'b1;
                     issue_addr_in = SW'(rd_addr_ff - 1'b1);
                     issue_more_in = 1'b1;
                     rd_valid_in   = 1'b0;
                  end
               end else begin
                  // resume the next walk at the term just found
                  res_coef_in = hit_coef_ff;
                  res_exp_in  = TERM_EXP_W'(hit_addr_ff);
                  res_last_in = 1'b0;
                  if (use_prod_ff) begin
                     prod_cursor_in = PW'(rd_addr_ff);
                  end else begin
                     sum_cursor_in = TW'(rd_addr_ff);
                  end
                  state_in = S_EMIT;
               end
            end else if (rd_valid_ff && (rd_addr_ff == '0)) begin
               // walked off the bottom
               if (!phase_ff) begin
                  res_coef_in = '0;
                  res_exp_in  = '0;
               end else begin
                  res_coef_in = hit_coef_ff;
                  res_exp_in  = TERM_EXP_W'(hit_addr_ff);
               end
               res_last_in = 1'b1;
               if (use_prod_ff) begin
                  prod_done_in = 1'b1;
               end else begin
                  sum_done_in = 1'b1;
               end
               state_in = S_EMIT;
            end else if (issue_more_ff) begin
               rd_valid_in   = 1'b1;
               rd_addr_in    = issue_addr_ff;
               issue_addr_in = SW'(issue_addr_ff - 1'b1);
               issue_more_in = (issue_addr_ff != '0);
            end else begin
               rd_valid_in = 1'b0;
            end
         end

         // hand the term to the response register once it is free
         S_EMIT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_coef_in  = res_coef_ff;
               out_exp_in   = res_exp_ff;
               out_last_in  = res_last_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         sweep_ff       <= '0;
         issue_more_ff  <= 1'b0;
         rd_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prod_cursor_ff <= PW'(PRODUCT_SLOTS - 1);
         sum_cursor_ff  <= TW'(TERM_SLOTS - 1);
         prod_done_ff   <= 1'b0;
         sum_done_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         issue_more_ff  <= issue_more_in;
         rd_valid_ff    <= rd_valid_in;
         out_valid_ff   <= out_valid_in;
         prod_cursor_ff <= prod_cursor_in;
         sum_cursor_ff  <= sum_cursor_in;
         prod_done_ff   <= prod_done_in;
         sum_done_ff    <= sum_done_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      issue_addr_ff <= issue_addr_in;
      rd_addr_ff    <= rd_addr_in;
      phase_ff      <= phase_in;
      use_prod_ff   <= use_prod_in;
      hit_addr_ff   <= hit_addr_in;
      hit_coef_ff   <= hit_coef_in;
      res_coef_ff   <= res_coef_in;
      res_exp_ff    <= res_exp_in;
      res_last_ff   <= res_last_in;
      out_coef_ff   <= out_coef_in;
      out_exp_ff    <= out_exp_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.term_coefficient = out_coef_ff;
   assign rsp_bus.term_exponent    = out_exp_ff;
   assign rsp_bus.final_term       = out_last_ff;

endmodule

@@ rtl/core/dense_polynomial_mul_add.sv @@
// dense polynomial multiply and add: load, clear, compute and fetch requests
// one request at a time; the next is taken once the sequencer is back in idle
// load writes one term store slot; clear zeroes both term stores; compute
// zeroes the product store, then multiplies each row with a nonzero first
// coefficient, skipping zero rows; fetch may wait on the response register
// reset: clearing pass over every store, no requests taken
`timescale 1ns / 1ps
`include "dense_polynomial_mul_add_defines.svh"

module dense_polynomial_mul_add
   import dpma_pkg::*;
#(
   parameter int TERM_SLOTS    = 1024,
   parameter int PRODUCT_SLOTS = 2047,
   parameter int COEF_BITS     = 16
) (
   input  logic       clock,
   input  logic       reset,
   dpma_req_if.sink   req_bus,
   dpma_rsp_if.source rsp_bus
);

   localparam int TW = $clog2(TERM_SLOTS);
   localparam int PW = $clog2(PRODUCT_SLOTS);

   logic                   first_wr_en, second_wr_en;
   logic [TW-1:0]          term_wr_addr;
   logic [COEF_BITS-1:0]   term_wr_data;
   logic [TW-1:0]          first_rd_addr, second_rd_addr;
   logic [COEF_BITS-1:0]   first_rd_data, second_rd_data;
   logic                   prod_sweep_en;
   logic [PW-1:0]          prod_sweep_addr;
   logic [PW-1:0]          prod_rd_addr;
   logic [TERM_COEF_W-1:0] prod_rd_data;
   dpma_mac_ctl_type       mac_ctl;
   logic [PW-1:0]          mac_addr;
   logic                   mac_wr_en;
   logic [PW-1:0]          mac_wr_addr;
   logic [TERM_COEF_W-1:0] mac_wr_data;
   logic                   prod_wr_en;
   logic [PW-1:0]          prod_wr_addr;
   logic [TERM_COEF_W-1:0] prod_wr_data;
   logic                   rsp_zero_coef;
   logic                   rsp_zero_form;

   // sequencer
   dpma_ctrl #(
      .TERM_SLOTS   (TERM_SLOTS),
      .PRODUCT_SLOTS(PRODUCT_SLOTS),
      .COEF_BITS    (COEF_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .first_wr_en    (first_wr_en),
      .second_wr_en   (second_wr_en),
      .term_wr_addr   (term_wr_addr),
      .term_wr_data   (term_wr_data),
      .first_rd_addr  (first_rd_addr),
      .second_rd_addr (second_rd_addr),
      .first_rd_data  (first_rd_data),
      .second_rd_data (second_rd_data),
      .prod_sweep_en  (prod_sweep_en),
      .prod_sweep_addr(prod_sweep_addr),
      .prod_rd_addr   (prod_rd_addr),
      .prod_rd_data   (prod_rd_data),
      .mac_ctl        (mac_ctl),
      .mac_addr       (mac_addr)
   );

   // coefficient stores
   dpma_ram #(.DEPTH(TERM_SLOTS), .WIDTH(COEF_BITS)) u_first_ram (
      .clock  (clock),
      .wr_en  (first_wr_en),
      .wr_addr(term_wr_addr),
      .wr_data(term_wr_data),
      .rd_addr(first_rd_addr),
      .rd_data(first_rd_data)
   );

   dpma_ram #(.DEPTH(TERM_SLOTS), .WIDTH(COEF_BITS)) u_second_ram (
      .clock  (clock),
      .wr_en  (second_wr_en),
      .wr_addr(term_wr_addr),
      .wr_data(term_wr_data),
      .rd_addr(second_rd_addr),
      .rd_data(second_rd_data)
   );

   // product store, written by the zeroing sweep or the accumulate pipe
   assign prod_wr_en   = mac_wr_en || prod_sweep_en;
   assign prod_wr_addr = mac_wr_en ? mac_wr_addr : prod_sweep_addr;
   assign prod_wr_data = mac_wr_en ? mac_wr_data : '0;

   dpma_ram #(.DEPTH(PRODUCT_SLOTS), .WIDTH(TERM_COEF_W)) u_prod_ram (
      .clock  (clock),
      .wr_en  (prod_wr_en),
      .wr_addr(prod_wr_addr),
      .wr_data(prod_wr_data),
      .rd_addr(prod_rd_addr),
      .rd_data(prod_rd_data)
   );

   // multiply-accumulate pipe
   dpma_mac #(
      .PRODUCT_SLOTS(PRODUCT_SLOTS),
      .COEF_BITS    (COEF_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_ctl (mac_ctl),
      .mac_addr(mac_addr),
      .a_data  ($signed(first_rd_data)),
      .b_data  ($signed(second_rd_data)),
      .old_data(prod_rd_data),
      .wr_en   (mac_wr_en),
      .wr_addr (mac_wr_addr),
      .wr_data (mac_wr_data)
   );

   // a zero coefficient only ever comes out as the lone term of a zero polynomial
   assign rsp_zero_coef = rsp_bus.valid && (rsp_bus.term_coefficient == '0);
   assign rsp_zero_form = (rsp_bus.term_exponent == '0) && rsp_bus.final_term;

   // checks
   `DPMA_ASSERT_IMPL(a_prod_wr_excl, clock, reset, mac_wr_en, !prod_sweep_en)
   `DPMA_ASSERT_IMPL(a_mac_wr_issued, clock, reset, mac_wr_en, $past(mac_ctl.valid, 2))
   `DPMA_ASSERT_IMPL(a_zero_term, clock, reset, rsp_zero_coef, rsp_zero_form)

endmodule
